### rtl/core/iso8601_pkg.sv
// Shared types, constants and calendar tables for the ISO 8601 timestamp parser.
package iso8601_pkg;

  localparam int TEXT_LEN       = 19;
  localparam int MQ_DEPTH       = 4;
  localparam int MQ_AW          = 2;
  localparam int OQ_DEPTH       = 8;
  localparam int OQ_AW          = 3;
  localparam int EPOCH_YEAR     = 1970;
  localparam int DAYS_PER_YEAR  = 365;
  localparam int LEAPS_TO_EPOCH = 477;  // leap days in years 1..1969
  localparam int SEC_PER_DAY    = 86400;
  localparam int SEC_PER_HOUR   = 3600;
  localparam int SEC_PER_MIN    = 60;
  localparam int RECIP25        = 1311; // x / 25 == (x * 1311) >> 15 for x < 4699
  localparam int RECIP_SHIFT    = 15;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SHORT = 3'd1,
    ST_SEP   = 3'd2,
    ST_RANGE = 3'd3,
    ST_EARLY = 3'd4
  } status_t;

  typedef struct packed {
    logic [14:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
    logic        too_short;
    logic        sep_bad;
  } rec_t;

  typedef struct packed {
    logic [37:0] epoch;
    status_t     status;
  } res_t;

  function automatic logic [4:0] month_days(input logic [3:0] mo, input logic leap);
    logic [4:0] d;
    case (mo)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      4'd2:                                       d = leap ? 5'd29 : 5'd28;
      default:                                    d = 5'd0;
    endcase
    return d;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] mo);
    logic [8:0] d;
    case (mo)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

### rtl/core/iso8601_text_to_epoch_seconds.sv
// Top level: ISO 8601 timestamp text to epoch seconds converter.
// Takes one text character per word and returns one result word per text,
// at the character marked end_of_text. A new character is taken every cycle
// while full is low; full rises only when the four-entry record queue behind
// the scanner is full. Each result reaches the output queue through the
// calendar pipeline (magnitude, divide-by-25 products, checks, day count,
// seconds multiply, final add), fed only while the output queue has room.
// Results drain from an eight-entry queue at one word per cycle while any wait.
// Status codes: 0 ok, 1 too short, 2 bad separator, 3 field out of range,
// 4 year before 1970; epoch_seconds is 0 whenever status is not 0.
module iso8601_text_to_epoch_seconds (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_text_char,
  input  logic        in_end_of_text,
  output logic        empty,
  input  logic        pop,
  output logic [37:0] out_epoch_seconds,
  output logic [2:0]  out_parse_status
);
  import iso8601_pkg::*;

  logic char_valid;
  logic rec_push, mq_full, mq_empty, mq_pop;
  rec_t rec_in, rec_out;

  assign full       = mq_full;
  assign char_valid = push && !mq_full;

  iso8601_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .char_valid  (char_valid),
    .text_char   (in_text_char),
    .end_of_text (in_end_of_text),
    .rec_push    (rec_push),
    .rec         (rec_in)
  );

  iso8601_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (rec_push),
    .wr_rec (rec_in),
    .full   (mq_full),
    .rd_en  (mq_pop),
    .rd_rec (rec_out),
    .empty  (mq_empty)
  );

  iso8601_calc u_calc (
    .clk           (clk),
    .rst_n         (rst_n),
    .rec           (rec_out),
    .rec_empty     (mq_empty),
    .rec_pop       (mq_pop),
    .empty         (empty),
    .pop           (pop),
    .epoch_seconds (out_epoch_seconds),
    .parse_status  (out_parse_status)
  );

endmodule

### rtl/core/iso8601_scan.sv
// Front end: per-character field scanner that emits one parsed record per text.
module iso8601_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                char_valid,
  input  logic [7:0]          text_char,
  input  logic                end_of_text,
  output logic                rec_push,
  output iso8601_pkg::rec_t   rec
);
  import iso8601_pkg::*;

  typedef enum logic [1:0] {PH_SKIP, PH_DIGITS, PH_DONE} phase_t;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  logic [4:0]  pos_r, pos_nxt;
  logic        sep_ok_r, sep_ok_nxt;
  logic [14:0] year_r, year_nxt;
  logic [7:0]  fld_r [0:4];
  logic [7:0]  fld_nxt [0:4];
  phase_t      phase_r, phase_nxt;
  logic        neg_r, neg_nxt;

  logic        in_text, start, is_sep, is_ws, is_dig, is_sgn, do_acc;
  logic [7:0]  sep_want;
  logic [2:0]  fidx, sidx;
  logic [14:0] cur, prod, digit, upd;
  phase_t      ph;
  logic        ng;

  always_comb begin
    pos_nxt    = pos_r;
    sep_ok_nxt = sep_ok_r;
    year_nxt   = year_r;
    fld_nxt    = fld_r;
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    do_acc     = 1'b0;

    in_text = pos_r < 5'(TEXT_LEN);
    start   = (pos_r == 5'd0) || (pos_r == 5'd5) || (pos_r == 5'd8) ||
              (pos_r == 5'd11) || (pos_r == 5'd14) || (pos_r == 5'd17);
    is_sep  = (pos_r == 5'd4) || (pos_r == 5'd7) || (pos_r == 5'd10) ||
              (pos_r == 5'd13) || (pos_r == 5'd16);
    if ((pos_r == 5'd4) || (pos_r == 5'd7)) begin
      sep_want = CH_DASH;
    end else if (pos_r == 5'd10) begin
      sep_want = CH_T;
    end else begin
      sep_want = CH_COLON;
    end

    if (pos_r <= 5'd3) begin
      fidx = 3'd0;
    end else if (pos_r <= 5'd6) begin
      fidx = 3'd1;
    end else if (pos_r <= 5'd9) begin
      fidx = 3'd2;
    end else if (pos_r <= 5'd12) begin
      fidx = 3'd3;
    end else if (pos_r <= 5'd15) begin
      fidx = 3'd4;
    end else begin
      fidx = 3'd5;
    end
    sidx = (fidx == 3'd0) ? 3'd0 : 3'(fidx - 3'd1);

    cur = (fidx == 3'd0) ? year_r : {{7{fld_r[sidx][7]}}, fld_r[sidx]};

    is_ws  = (text_char == CH_SPACE) || ((text_char >= CH_TAB) && (text_char <= CH_CR));
    is_dig = (text_char >= CH_ZERO) && (text_char <= CH_NINE);
    is_sgn = (text_char == CH_PLUS) || (text_char == CH_DASH);

    ph    = start ? PH_SKIP : phase_r;
    ng    = start ? 1'b0 : neg_r;
    digit = {11'd0, text_char[3:0]};
    prod  = 15'(cur << 3) + 15'(cur << 1);
    upd   = ng ? 15'(prod - digit) : 15'(prod + digit);

    if (in_text) begin
      pos_nxt = 5'(pos_r + 5'd1);
      if (is_sep) begin
        if (text_char != sep_want) begin
          sep_ok_nxt = 1'b0;
        end
      end else begin
        phase_nxt = ph;
        neg_nxt   = ng;
        case (ph)
          PH_SKIP: begin
            if (is_ws) begin
              phase_nxt = PH_SKIP;
            end else if (is_sgn) begin
              neg_nxt   = (text_char == CH_DASH);
              phase_nxt = PH_DIGITS;
            end else if (!is_dig) begin
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_DIGITS;
              do_acc    = 1'b1;
            end
          end
          PH_DIGITS: begin
            if (!is_dig) begin
              phase_nxt = PH_DONE;
            end else begin
              do_acc = 1'b1;
            end
          end
          default: begin
            phase_nxt = PH_DONE;
          end
        endcase
        if (do_acc) begin
          if (fidx == 3'd0) begin
            year_nxt = upd;
          end else begin
            fld_nxt[sidx] = upd[7:0];
          end
        end
      end
    end

    rec_push      = char_valid && end_of_text;
    rec.year      = year_nxt;
    rec.month     = fld_nxt[0];
    rec.day       = fld_nxt[1];
    rec.hour      = fld_nxt[2];
    rec.minute    = fld_nxt[3];
    rec.second    = fld_nxt[4];
    rec.too_short = pos_nxt < 5'(TEXT_LEN);
    rec.sep_bad   = !sep_ok_nxt;

    if (end_of_text) begin
      pos_nxt    = 5'd0;
      sep_ok_nxt = 1'b1;
      year_nxt   = '0;
      for (int i = 0; i < 5; i++) begin
        fld_nxt[i] = '0;
      end
      phase_nxt  = PH_SKIP;
      neg_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      sep_ok_r <= 1'b1;
      year_r   <= '0;
      for (int i = 0; i < 5; i++) begin
        fld_r[i] <= '0;
      end
      phase_r  <= PH_SKIP;
      neg_r    <= 1'b0;
    end else if (char_valid) begin
      pos_r    <= pos_nxt;
      sep_ok_r <= sep_ok_nxt;
      year_r   <= year_nxt;
      fld_r    <= fld_nxt;
      phase_r  <= phase_nxt;
      neg_r    <= neg_nxt;
    end
  end

endmodule

### rtl/core/iso8601_queue.sv
// Short record queue between the scanner and the calendar pipeline.
module iso8601_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  iso8601_pkg::rec_t wr_rec,
  output logic              full,
  input  logic              rd_en,
  output iso8601_pkg::rec_t rd_rec,
  output logic              empty
);
  import iso8601_pkg::*;

  rec_t             mem_r [0:MQ_DEPTH-1];
  logic [MQ_AW-1:0] wp_r, rp_r;
  logic [MQ_AW:0]   cnt_r;
  logic             do_wr, do_rd;

  assign full   = cnt_r == (MQ_AW+1)'(MQ_DEPTH);
  assign empty  = cnt_r == '0;
  assign rd_rec = mem_r[rp_r];
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= MQ_AW'(wp_r + 1'b1);
      end
      if (do_rd) begin
        rp_r <= MQ_AW'(rp_r + 1'b1);
      end
      cnt_r <= (MQ_AW+1)'(cnt_r + (MQ_AW+1)'(do_wr) - (MQ_AW+1)'(do_rd));
    end
  end

endmodule

### rtl/core/iso8601_calc.sv
// Back end: calendar checks and epoch arithmetic pipeline with result queue.
module iso8601_calc (
  input  logic              clk,
  input  logic              rst_n,
  input  iso8601_pkg::rec_t rec,
  input  logic              rec_empty,
  output logic              rec_pop,
  output logic              empty,
  input  logic              pop,
  output logic [37:0]       epoch_seconds,
  output logic [2:0]        parse_status
);
  import iso8601_pkg::*;

  // stage valids
  logic va_r, vb_r, vc_r, vd_r, ve_r;
  logic [2:0] inflight;

  // stage A
  rec_t        a_rec_r;
  logic [14:0] a_abs_r;
  logic [13:0] a_pm1_r, a_yoff_r;
  logic        a_early_r;
  logic [14:0] abs_y;

  // stage B
  rec_t        b_rec_r;
  logic [14:0] b_abs_r;
  logic [13:0] b_pm1_r;
  logic        b_early_r;
  logic [23:0] b_ma4_r, b_ma16_r, b_mp4_r, b_mp16_r;
  logic [22:0] b_yd_r;

  // stage C
  logic [7:0]  qa4, qa16, qp4, qp16;
  logic        div4, div16, leap, mo_ok, dy_ok, hr_ok, mi_ok, sc_ok;
  logic [4:0]  dim;
  status_t     status;
  status_t     c_status_r;
  logic [11:0] c_leaps_r;
  logic [8:0]  c_cum_r;
  logic [22:0] c_yd_r;
  logic [4:0]  c_day_r, c_hour_r;
  logic [5:0]  c_min_r, c_sec_r;

  // stage D
  status_t     d_status_r;
  logic [22:0] d_days_r;
  logic [4:0]  d_hour_r;
  logic [5:0]  d_min_r, d_sec_r;

  // stage E
  status_t     e_status_r;
  logic [39:0] e_dsec_r;
  logic [16:0] e_tod_r;
  logic [39:0] total;
  res_t        res;

  // result queue
  res_t             oq_r [0:OQ_DEPTH-1];
  logic [OQ_AW-1:0] oq_wp_r, oq_rp_r;
  logic [OQ_AW:0]   oq_cnt_r;
  logic             oq_rd;

  assign inflight = 3'(va_r) + 3'(vb_r) + 3'(vc_r) + 3'(vd_r) + 3'(ve_r);
  assign rec_pop  = !rec_empty &&
                    ((5'(oq_cnt_r) + 5'(inflight)) < 5'(OQ_DEPTH));

  assign abs_y = rec.year[14] ? 15'(-rec.year) : rec.year;

  always_ff @(posedge clk) begin
    a_rec_r   <= rec;
    a_abs_r   <= abs_y;
    a_pm1_r   <= 14'(rec.year - 15'd1);
    a_yoff_r  <= 14'(rec.year - 15'(EPOCH_YEAR));
    a_early_r <= $signed(rec.year) < $signed(15'(EPOCH_YEAR));

    b_rec_r   <= a_rec_r;
    b_abs_r   <= a_abs_r;
    b_pm1_r   <= a_pm1_r;
    b_early_r <= a_early_r;
    b_ma4_r   <= 24'(a_abs_r[14:2]) * 24'(RECIP25);
    b_ma16_r  <= 24'(a_abs_r[14:4]) * 24'(RECIP25);
    b_mp4_r   <= 24'(a_pm1_r[13:2]) * 24'(RECIP25);
    b_mp16_r  <= 24'(a_pm1_r[13:4]) * 24'(RECIP25);
    b_yd_r    <= 23'(a_yoff_r) * 23'(DAYS_PER_YEAR);
  end

  always_comb begin
    qa4   = b_ma4_r[RECIP_SHIFT +: 8];
    qa16  = b_ma16_r[RECIP_SHIFT +: 8];
    qp4   = b_mp4_r[RECIP_SHIFT +: 8];
    qp16  = b_mp16_r[RECIP_SHIFT +: 8];
    div4  = b_abs_r[14:2] == 13'(13'(qa4) * 13'd25);
    div16 = b_abs_r[14:4] == 11'(11'(qa16) * 11'd25);
    leap  = ((b_abs_r[1:0] == 2'd0) && !div4) || ((b_abs_r[3:0] == 4'd0) && div16);
    dim   = month_days(b_rec_r.month[3:0], leap);
    mo_ok = ($signed(b_rec_r.month) >= 8'sd1) && ($signed(b_rec_r.month) <= 8'sd12);
    dy_ok = ($signed(b_rec_r.day) >= 8'sd1) && (b_rec_r.day <= {3'd0, dim});
    hr_ok = !b_rec_r.hour[7] && (b_rec_r.hour <= 8'd23);
    mi_ok = !b_rec_r.minute[7] && (b_rec_r.minute <= 8'd59);
    sc_ok = !b_rec_r.second[7] && (b_rec_r.second <= 8'd59);
    if (b_rec_r.too_short) begin
      status = ST_SHORT;
    end else if (b_rec_r.sep_bad) begin
      status = ST_SEP;
    end else if (!(mo_ok && dy_ok && hr_ok && mi_ok && sc_ok)) begin
      status = ST_RANGE;
    end else if (b_early_r) begin
      status = ST_EARLY;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    c_status_r <= status;
    c_leaps_r  <= 12'(b_pm1_r[13:2]) - 12'(qp4) + 12'(qp16);
    c_cum_r    <= days_before(b_rec_r.month[3:0]) +
                  9'(leap && (b_rec_r.month[3:0] > 4'd2));
    c_yd_r     <= b_yd_r;
    c_day_r    <= b_rec_r.day[4:0];
    c_hour_r   <= b_rec_r.hour[4:0];
    c_min_r    <= b_rec_r.minute[5:0];
    c_sec_r    <= b_rec_r.second[5:0];

    d_status_r <= c_status_r;
    d_days_r   <= c_yd_r + 23'(c_leaps_r) + 23'(c_cum_r) + 23'(c_day_r) -
                  23'(LEAPS_TO_EPOCH + 1);
    d_hour_r   <= c_hour_r;
    d_min_r    <= c_min_r;
    d_sec_r    <= c_sec_r;

    e_status_r <= d_status_r;
    e_dsec_r   <= 40'(d_days_r) * 40'(SEC_PER_DAY);
    e_tod_r    <= 17'(d_hour_r) * 17'(SEC_PER_HOUR) + 17'(d_min_r) * 17'(SEC_PER_MIN) +
                  17'(d_sec_r);
  end

  always_comb begin
    total      = e_dsec_r + 40'(e_tod_r);
    res.status = e_status_r;
    res.epoch  = (e_status_r == ST_OK) ? total[37:0] : 38'd0;
  end

  assign empty         = oq_cnt_r == '0;
  assign oq_rd         = pop && !empty;
  assign epoch_seconds = oq_r[oq_rp_r].epoch;
  assign parse_status  = oq_r[oq_rp_r].status;

  always_ff @(posedge clk) begin
    if (ve_r) begin
      oq_r[oq_wp_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r     <= 1'b0;
      vb_r     <= 1'b0;
      vc_r     <= 1'b0;
      vd_r     <= 1'b0;
      ve_r     <= 1'b0;
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      va_r <= rec_pop;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
      if (ve_r) begin
        oq_wp_r <= OQ_AW'(oq_wp_r + 1'b1);
      end
      if (oq_rd) begin
        oq_rp_r <= OQ_AW'(oq_rp_r + 1'b1);
      end
      oq_cnt_r <= (OQ_AW+1)'(oq_cnt_r + (OQ_AW+1)'(ve_r) - (OQ_AW+1)'(oq_rd));
    end
  end

endmodule

### rtl/core/iso8601_checker.sv
// Port-level assertions for the timestamp converter, bound to the top level.
module iso8601_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        push,
  input logic        full,
  input logic [7:0]  in_text_char,
  input logic        in_end_of_text,
  input logic        empty,
  input logic        pop,
  input logic [37:0] out_epoch_seconds,
  input logic [2:0]  out_parse_status
);
  import iso8601_pkg::*;

  // failed parse carries a zero epoch
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_parse_status != ST_OK)) |-> (out_epoch_seconds == 38'd0))
    else $error("nonzero epoch on failed parse");

  // reset leaves both queues open and empty
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not clear after reset");

  // no result can reach the output right after reset
  a_no_early_word: assert property (@(posedge clk)
    !rst_n |=> ##1 empty)
    else $error("result word too soon after reset");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_epoch_seconds) &&
                          $stable(out_parse_status)))
    else $error("stalled result word changed");

endmodule

bind iso8601_text_to_epoch_seconds iso8601_checker u_chk (.*);
